>>> rtl/ipj_pkg.sv
package ipj_pkg;

  // Field and register widths.
  localparam int VOX_W      = 8;
  localparam int ACC_W      = 16;
  localparam int ADDR_W     = 16;
  localparam int SIZE_W     = 9;
  localparam int CNT_W      = 8;
  localparam int DIR_W      = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Volume size limits.
  localparam logic [SIZE_W-1:0] MAX_ROW    = 9'd256;
  localparam logic [SIZE_W-1:0] MAX_COL    = 9'd256;
  localparam logic [SIZE_W-1:0] MAX_PLANES = 9'd256;

  // Accumulator store depth.
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] IDX_ROW_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_COL_SIZE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_PLANE_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_DIRECTION   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_MODE        = 3'd4;

  // Projection axis codes.
  localparam logic [DIR_W-1:0] DIR_X = 2'd0;
  localparam logic [DIR_W-1:0] DIR_Y = 2'd1;
  localparam logic [DIR_W-1:0] DIR_Z = 2'd2;

  // Raw mode register codes.
  localparam logic [MODE_W-1:0] MODE_CODE_MEAN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_MAX  = 2'd1;

  // Operating mode after decoding.
  typedef enum logic [MODE_W-1:0] {
    MODE_MEAN = 2'd0,
    MODE_MAX  = 2'd1,
    MODE_SUM  = 2'd2
  } mode_t;

  // Operation queue between front and back; the depth is a power of two.
  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
  localparam logic [OPQ_PTR_W:0] OPQ_FULL_CNT = (OPQ_PTR_W+1)'(OPQ_DEPTH);

  // Mean divider: dividend 2*acc+len, divisor 2*len.
  localparam int DIV_N_W   = ACC_W + 2;
  localparam int DIV_D_W   = SIZE_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // One classified voxel, as handed from front to back.
  typedef struct packed {
    logic [VOX_W-1:0]  voxel;
    logic [ADDR_W-1:0] addr;
    logic              first;
    logic              done;
    logic              last;
    logic [SIZE_W-1:0] line_len;
    mode_t             mode;
  } op_t;

  // One finished result offered by the back part.
  typedef struct packed {
    logic              valid;
    logic [ACC_W-1:0]  value;
    logic [ADDR_W-1:0] index;
    logic              last;
  } res_t;

  // A size of zero acts as one, a size above the limit acts as the limit.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/ipj_front.sv
module ipj_front
  import ipj_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  input  logic [VOX_W-1:0]      in_voxel,
  input  logic                  opq_full,
  output logic                  opq_wr,
  output op_t                   opq_data
);

  logic [SIZE_W-1:0] row_size_r, col_size_r, plane_count_r;
  logic [DIR_W-1:0]  direction_r;
  logic [MODE_W-1:0] mode_r;
  logic [CNT_W-1:0]  col_r, row_r, plane_r;
  logic [CNT_W-1:0]  col_nxt, row_nxt, plane_nxt;

  logic [SIZE_W-1:0] rs, cs, ds;
  logic [SIZE_W-1:0] col_inc, row_inc, plane_inc;
  logic              col_end, row_end, plane_end;
  logic              cfg_known;

  logic [CNT_W-1:0]        mul_a, add_term, pos;
  logic [SIZE_W-1:0]       mul_b, line_len;
  logic [CNT_W+SIZE_W-1:0] prod;
  logic [ADDR_W-1:0]       addr_sum;
  logic [SIZE_W-1:0]       pos_inc;
  mode_t                   mode_dec;

  assign rs = clamp_size(row_size_r, MAX_ROW);
  assign cs = clamp_size(col_size_r, MAX_COL);
  assign ds = clamp_size(plane_count_r, MAX_PLANES);

  assign cfg_known = cfg_wr && (cfg_index <= IDX_MODE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_size_r    <= 9'd256;
      col_size_r    <= 9'd256;
      plane_count_r <= 9'd1;
      direction_r   <= DIR_Z;
      mode_r        <= MODE_CODE_MEAN;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        IDX_ROW_SIZE:    row_size_r    <= cfg_data;
        IDX_COL_SIZE:    col_size_r    <= cfg_data;
        IDX_PLANE_COUNT: plane_count_r <= cfg_data;
        IDX_DIRECTION:   direction_r   <= cfg_data[DIR_W-1:0];
        IDX_MODE:        mode_r        <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Position of the current voxel inside the volume.
  assign col_inc   = {1'b0, col_r} + SIZE_W'(1);
  assign row_inc   = {1'b0, row_r} + SIZE_W'(1);
  assign plane_inc = {1'b0, plane_r} + SIZE_W'(1);
  assign col_end   = col_inc >= rs;
  assign row_end   = row_inc >= cs;
  assign plane_end = plane_inc >= ds;

  // Pick the projection line that this voxel belongs to.
  always_comb begin
    unique case (direction_r)
      DIR_X: begin
        mul_a = plane_r; mul_b = cs; add_term = row_r; line_len = rs; pos = col_r;
      end
      DIR_Y: begin
        mul_a = plane_r; mul_b = rs; add_term = col_r; line_len = cs; pos = row_r;
      end
      default: begin
        mul_a = row_r; mul_b = rs; add_term = col_r; line_len = ds; pos = plane_r;
      end
    endcase
  end

  // The store address wraps at the store depth.
  assign prod     = mul_a * mul_b;
  assign addr_sum = ADDR_W'(prod + (CNT_W+SIZE_W)'(add_term));
  assign pos_inc  = {1'b0, pos} + SIZE_W'(1);

  // The unused mode codes behave as sum.
  always_comb begin
    unique case (mode_r)
      MODE_CODE_MEAN: mode_dec = MODE_MEAN;
      MODE_CODE_MAX:  mode_dec = MODE_MAX;
      default:        mode_dec = MODE_SUM;
    endcase
  end

  assign opq_wr = in_push && !opq_full;

  always_comb begin
    opq_data.voxel    = in_voxel;
    opq_data.addr     = addr_sum;
    opq_data.first    = (pos == '0);
    opq_data.done     = pos_inc >= line_len;
    opq_data.last     = col_end && row_end && plane_end;
    opq_data.line_len = line_len;
    opq_data.mode     = mode_dec;
  end

  // Raster counters: column fastest, then row, then plane.
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    plane_nxt = plane_r;
    if (cfg_known) begin
      col_nxt   = '0;
      row_nxt   = '0;
      plane_nxt = '0;
    end else if (opq_wr) begin
      col_nxt = col_inc[CNT_W-1:0];
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_inc[CNT_W-1:0];
        if (row_end) begin
          row_nxt   = '0;
          plane_nxt = plane_end ? '0 : plane_inc[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      plane_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      plane_r <= plane_nxt;
    end
  end

endmodule

>>> rtl/ipj_opq.sv
module ipj_opq
  import ipj_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  op_t  wr_data,
  input  logic rd,
  output op_t  rd_data,
  output logic full,
  output logic empty
);

  op_t                q_r [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OPQ_PTR_W:0]   cnt_r;

  assign full    = (cnt_r == OPQ_FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign rd_data = q_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= wr_ptr_r + OPQ_PTR_W'(1);
      end
      if (rd) begin
        rd_ptr_r <= rd_ptr_r + OPQ_PTR_W'(1);
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + (OPQ_PTR_W+1)'(1);
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - (OPQ_PTR_W+1)'(1);
      end
    end
  end

endmodule

>>> rtl/ipj_div.sv
module ipj_div
  import ipj_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [ACC_W-1:0]   quotient
);

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_N_W-1:0]   n_r;
  logic [DIV_D_W-1:0]   rem_r, d_r;
  logic [DIV_D_W:0]     trial;
  logic                 q_bit;
  logic [DIV_D_W-1:0]   rem_nxt;
  logic [DIV_D_W-1:0]   trial_diff;

  assign done     = done_r;
  assign quotient = n_r[ACC_W-1:0];

  // One restoring step: bring down a dividend bit, subtract if it fits.
  // The difference is below the divisor, so the low bits carry it whole.
  assign trial      = {rem_r, n_r[DIV_N_W-1]};
  assign trial_diff = trial[DIV_D_W-1:0] - d_r;
  assign q_bit      = trial >= {1'b0, d_r};
  assign rem_nxt    = q_bit ? trial_diff : trial[DIV_D_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      n_r   <= {n_r[DIV_N_W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  // Step counter; done pulses once the last quotient bit is in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_N_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/ipj_back.sv
module ipj_back
  import ipj_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  op_t  opq_data,
  input  logic opq_empty,
  output logic opq_rd,
  output res_t res,
  input  logic res_ready
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_CALC = 4'b0010,
    B_DIV  = 4'b0100,
    B_EMIT = 4'b1000
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [ACC_W-1:0]  acc_mem [MEM_DEPTH];
  logic [ACC_W-1:0]  rd_data_r;
  op_t               op_r;
  logic [ACC_W-1:0]  value_r;

  logic [ACC_W-1:0]   base, acc;
  logic [ACC_W:0]     sum_ext;
  logic               calc, mem_we;
  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_n;
  logic [ACC_W-1:0]   div_q;
  logic [DIV_D_W-1:0] div_d;

  assign opq_rd = (state_r == B_IDLE) && !opq_empty;
  assign calc   = (state_r == B_CALC);

  // Accumulator store, read at the queue head so data is ready in the calc cycle.
  always_ff @(posedge clk) begin
    rd_data_r <= acc_mem[opq_data.addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      acc_mem[op_r.addr] <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (opq_rd) begin
      op_r <= opq_data;
    end
  end

  // Fold the voxel: the first voxel of a line loads, others add or take the max.
  assign base    = op_r.first ? '0 : rd_data_r;
  assign sum_ext = {1'b0, base} + (ACC_W+1)'(op_r.voxel);

  always_comb begin
    if (op_r.mode == MODE_MAX) begin
      acc = (ACC_W'(op_r.voxel) > base) ? ACC_W'(op_r.voxel) : base;
    end else begin
      acc = sum_ext[ACC_W] ? '1 : sum_ext[ACC_W-1:0];
    end
  end

  assign mem_we = calc;

  // Rounded mean: (2*acc + len) / (2*len).
  assign div_start = calc && op_r.done && (op_r.mode == MODE_MEAN);
  assign div_n     = {1'b0, acc, 1'b0} + DIV_N_W'(op_r.line_len);
  assign div_d     = {op_r.line_len, 1'b0};

  ipj_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // Result value capture.
  always_ff @(posedge clk) begin
    if (calc) begin
      value_r <= acc;
    end else if ((state_r == B_DIV) && div_done) begin
      value_r <= div_q;
    end
  end

  always_comb begin
    res.valid = (state_r == B_EMIT);
    res.value = value_r;
    res.index = op_r.addr;
    res.last  = op_r.last;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!opq_empty) begin
          state_nxt = B_CALC;
        end
      end
      B_CALC: begin
        if (!op_r.done) begin
          state_nxt = B_IDLE;
        end else if (op_r.mode == MODE_MEAN) begin
          state_nxt = B_DIV;
        end else begin
          state_nxt = B_EMIT;
        end
      end
      B_DIV: begin
        if (div_done) begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (res_ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/axis_projection_mean_max_sum.sv
// A voxel that completes a line in max or sum mode reaches the result ports through
// the queue, the calc and emit states of the back part and the output register; in
// mean mode it also passes the bit-serial mean divider. The back part takes no new
// voxel before the read-modify-write of the accumulator memory is done, nor after
// a line-ending voxel before its result is taken. A 4-entry queue buffers voxels.
// Reset clears counters, queues and control; registers return to their defaults.
module axis_projection_mean_max_sum
  import ipj_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [VOX_W-1:0]      in_voxel,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [ACC_W-1:0]      out_value,
  output logic [ADDR_W-1:0]     out_index,
  output logic                  out_last
);

  logic opq_wr, opq_rd, opq_full, opq_empty;
  op_t  opq_wdata, opq_rdata;
  res_t res;
  logic res_ready;

  logic              out_valid_r;
  logic [ACC_W-1:0]  out_value_r;
  logic [ADDR_W-1:0] out_index_r;
  logic              out_last_r;

  assign cfg_ready = 1'b1;
  assign in_full   = opq_full;

  ipj_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_voxel  (in_voxel),
    .opq_full  (opq_full),
    .opq_wr    (opq_wr),
    .opq_data  (opq_wdata)
  );

  ipj_opq u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (opq_wr),
    .wr_data (opq_wdata),
    .rd      (opq_rd),
    .rd_data (opq_rdata),
    .full    (opq_full),
    .empty   (opq_empty)
  );

  ipj_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .opq_data  (opq_rdata),
    .opq_empty (opq_empty),
    .opq_rd    (opq_rd),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register: the back part can finish the next result while this one waits.
  assign res_ready = !out_valid_r;

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_value_r <= res.value;
      out_index_r <= res.index;
      out_last_r  <= res.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_value = out_value_r;
  assign out_index = out_index_r;
  assign out_last  = out_last_r;

  // A result that cannot be transferred yet must still be offered next cycle.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res_ready) |=> res.valid)
    else $error("back result dropped while output register full");

  // The front part never writes a full operation queue.
  a_opq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    opq_wr |-> !opq_full)
    else $error("operation queue overflow");

  // The back part never reads an empty operation queue.
  a_opq_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    opq_rd |-> !opq_empty)
    else $error("operation queue underflow");

endmodule
